>>> src/tcnc_pkg.sv
// ----------------------------------------------------------------------------
// tcnc_pkg
// Shared types for the triangle cull and near-plane clip block.
// ----------------------------------------------------------------------------
package tcnc_pkg;

  localparam int unsigned AlphaBits = 16;
  localparam logic [AlphaBits-1:0] AlphaMax = '1;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] a_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] b_w;
    logic signed [31:0] c_x;
    logic signed [31:0] c_y;
    logic signed [31:0] c_z;
    logic signed [31:0] c_w;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic [1:0]         corner;
    logic               last_vertex;
  } out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
  } vtx_t;

  // pass: s0 s1 s2 as is
  // one behind: s0 = behind vertex, s1 = U, s2 = V
  // two behind: s0 = P, s1 = R, s2 = front vertex
  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_ONE,
    MODE_TWO
  } mode_t;

  typedef struct packed {
    mode_t mode;
    vtx_t  s0;
    vtx_t  s1;
    vtx_t  s2;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_EMIT
  } back_state_t;

  // component of a vertex by index x, y, z, w
  function automatic logic signed [31:0] vtx_comp(vtx_t v, logic [1:0] sel);
    logic signed [31:0] r;
    unique case (sel)
      2'd0: r = v.x;
      2'd1: r = v.y;
      2'd2: r = v.z;
      default: r = v.w;
    endcase
    return r;
  endfunction

endpackage

>>> src/tcnc_divider.sv
// ----------------------------------------------------------------------------
// tcnc_divider
// Bit-serial divider for the cut fraction alpha = (-pz << 16) / (qz - pz).
// ----------------------------------------------------------------------------
module tcnc_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] pz,
  input  logic signed [31:0] qz,
  output logic               busy,
  output logic [tcnc_pkg::AlphaBits-1:0] alpha
);
  import tcnc_pkg::*;

  logic [32:0] rem;
  logic [32:0] den;
  logic [AlphaBits-1:0] quo;
  logic sat;
  logic [4:0] cnt;

  logic [32:0] num_a;
  logic [32:0] den_a;
  logic [33:0] shifted;

  // operands at start: -pz and qz - pz, both positive
  always_comb begin
    num_a   = 33'd0 - {pz[31], pz};
    den_a   = {qz[31], qz} - {pz[31], pz};
    shifted = {rem, 1'b0};
  end

  // one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'(AlphaBits);
      rem  <= num_a;
      den  <= den_a;
      sat  <= (num_a >= den_a);
      quo  <= '0;
    end else if (busy) begin
      if (shifted >= {1'b0, den}) begin
        rem <= 33'(shifted - {1'b0, den});
        quo <= {quo[AlphaBits-2:0], 1'b1};
      end else begin
        rem <= shifted[32:0];
        quo <= {quo[AlphaBits-2:0], 1'b0};
      end
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

  // a quotient of one saturates
  assign alpha = sat ? AlphaMax : quo;

endmodule

>>> src/tcnc_front.sv
// ----------------------------------------------------------------------------
// tcnc_front
// Culls and classifies triangles and queues clip jobs for the back end.
// ----------------------------------------------------------------------------
module tcnc_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  tcnc_pkg::in_t  item,
  output logic           job_valid,
  output tcnc_pkg::job_t job,
  input  logic           job_take
);
  import tcnc_pkg::*;

  vtx_t va [3];
  logic bx, by, bfar, cull;
  logic [2:0] bz;
  job_t job_in;
  logic accept;

  job_t jq [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;

  // unpack vertices
  always_comb begin
    va[0] = '{x: item.a_x, y: item.a_y, z: item.a_z, w: item.a_w};
    va[1] = '{x: item.b_x, y: item.b_y, z: item.b_z, w: item.b_w};
    va[2] = '{x: item.c_x, y: item.c_y, z: item.c_z, w: item.c_w};
  end

  // outside tests, absolute values exact at 33 bits
  always_comb begin
    logic [32:0] ax, ay;
    logic signed [33:0] ws;
    bx = 1'b1;
    by = 1'b1;
    bfar = 1'b1;
    for (int i = 0; i < 3; i++) begin
      ax = va[i].x[31] ? 33'd0 - {1'b1, va[i].x} : {1'b0, va[i].x};
      ay = va[i].y[31] ? 33'd0 - {1'b1, va[i].y} : {1'b0, va[i].y};
      ws = {{2{va[i].w[31]}}, va[i].w};
      bx = bx & ($signed({1'b0, ax}) > ws);
      by = by & ($signed({1'b0, ay}) > ws);
      bfar = bfar & (va[i].z > va[i].w);
      bz[i] = va[i].z[31];
    end
    cull = bx | by | bfar | (&bz);
  end

  // arrange vertices for the back end
  always_comb begin
    job_in = '{mode: MODE_PASS, s0: va[0], s1: va[1], s2: va[2]};
    priority if (bz[0] && bz[1]) begin
      job_in = '{mode: MODE_TWO, s0: va[0], s1: va[1], s2: va[2]};
    end else if (bz[0] && bz[2]) begin
      job_in = '{mode: MODE_TWO, s0: va[0], s1: va[2], s2: va[1]};
    end else if (bz[0]) begin
      job_in = '{mode: MODE_ONE, s0: va[0], s1: va[1], s2: va[2]};
    end else if (bz[1] && bz[2]) begin
      job_in = '{mode: MODE_TWO, s0: va[1], s1: va[2], s2: va[0]};
    end else if (bz[1]) begin
      job_in = '{mode: MODE_ONE, s0: va[1], s1: va[0], s2: va[2]};
    end else if (bz[2]) begin
      job_in = '{mode: MODE_ONE, s0: va[2], s1: va[0], s2: va[1]};
    end else begin
      job_in = '{mode: MODE_PASS, s0: va[0], s1: va[1], s2: va[2]};
    end
  end

  assign full   = (count == 2'd2);
  assign accept = push & ~full & ~cull;

  // two-entry job queue
  always_ff @(posedge clk) begin
    if (accept) begin
      jq[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (accept) wr_ptr <= ~wr_ptr;
      if (job_take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, accept} - {1'b0, job_take};
    end
  end

  assign job_valid = (count != 2'd0);
  assign job       = jq[rd_ptr];

endmodule

>>> src/tcnc_back.sv
// ----------------------------------------------------------------------------
// tcnc_back
// Computes cut points and emits result vertices through a two-word queue.
// ----------------------------------------------------------------------------
module tcnc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  tcnc_pkg::job_t job,
  output logic           job_take,
  output logic           empty,
  input  logic           pop,
  output tcnc_pkg::out_t result
);
  import tcnc_pkg::*;

  back_state_t state, state_next;
  job_t cur;
  vtx_t cutv [2];
  logic [2:0] step;
  logic [2:0] idx;

  logic div_start;
  logic busy0, busy1;
  logic [AlphaBits-1:0] alpha0, alpha1;
  logic signed [31:0] pz0, qz0, pz1, qz1;

  logic signed [31:0] pc, qc, rc;
  logic signed [32:0] diff;
  logic signed [49:0] prod;
  logic [AlphaBits-1:0] alpha_sel;

  out_t oq [2];
  logic oq_wr, oq_rd;
  logic [1:0] oq_count;
  logic oq_push, oq_pop;
  out_t emit_word;
  logic last_idx;

  // cut endpoints by mode
  always_comb begin
    pz0 = job.s0.z;
    qz0 = (job.mode == MODE_ONE) ? job.s1.z : job.s2.z;
    pz1 = (job.mode == MODE_ONE) ? job.s0.z : job.s1.z;
    qz1 = job.s2.z;
  end

  tcnc_divider u_div0 (
    .clk, .rst, .start(div_start), .pz(pz0), .qz(qz0), .busy(busy0), .alpha(alpha0)
  );
  tcnc_divider u_div1 (
    .clk, .rst, .start(div_start), .pz(pz1), .qz(qz1), .busy(busy1), .alpha(alpha1)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (job_valid) state_next = (job.mode == MODE_PASS) ? ST_EMIT : ST_DIV;
      ST_DIV:  if (!busy0 && !busy1) state_next = ST_MUL;
      ST_MUL:  if (step == 3'd7) state_next = ST_EMIT;
      ST_EMIT: if (oq_push && last_idx) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    job_take  = (state == ST_IDLE) && job_valid;
    div_start = job_take && (job.mode != MODE_PASS);
    oq_push   = (state == ST_EMIT) && (oq_count != 2'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // interpolate one component per cycle
  always_comb begin
    vtx_t p, q;
    if (step[2]) begin
      p = (cur.mode == MODE_ONE) ? cur.s0 : cur.s1;
      q = cur.s2;
      alpha_sel = alpha1;
    end else begin
      p = cur.s0;
      q = (cur.mode == MODE_ONE) ? cur.s1 : cur.s2;
      alpha_sel = alpha0;
    end
    pc   = vtx_comp(p, step[1:0]);
    qc   = vtx_comp(q, step[1:0]);
    diff = {qc[31], qc} - {pc[31], pc};
    prod = diff * $signed({1'b0, alpha_sel});
    rc   = pc + prod[47:16];
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      cur <= job;
    end
    if (state == ST_MUL) begin
      unique case (step[1:0])
        2'd0: cutv[step[2]].x <= rc;
        2'd1: cutv[step[2]].y <= rc;
        2'd2: cutv[step[2]].z <= rc;
        default: cutv[step[2]].w <= rc;
      endcase
    end
  end

  // sequencing counters
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      idx  <= '0;
    end else begin
      if (state == ST_MUL) step <= step + 3'd1;
      else step <= '0;
      if (state != ST_EMIT) idx <= '0;
      else if (oq_push) idx <= idx + 3'd1;
    end
  end

  // vertex selection for the emitted word
  always_comb begin
    vtx_t v;
    logic [1:0] crn;
    last_idx = (cur.mode == MODE_ONE) ? (idx == 3'd5) : (idx == 3'd2);
    crn = (idx >= 3'd3) ? 2'(idx - 3'd3) : idx[1:0];
    v = cur.s2;
    unique case (cur.mode)
      MODE_ONE: begin
        unique case (idx)
          3'd0, 3'd4: v = cutv[0];
          3'd1:       v = cur.s1;
          3'd3:       v = cutv[1];
          default:    v = cur.s2;
        endcase
      end
      MODE_TWO: begin
        unique case (idx)
          3'd0:    v = cutv[0];
          3'd1:    v = cutv[1];
          default: v = cur.s2;
        endcase
      end
      default: begin
        unique case (idx)
          3'd0:    v = cur.s0;
          3'd1:    v = cur.s1;
          default: v = cur.s2;
        endcase
      end
    endcase
    emit_word = '{out_x: v.x, out_y: v.y, out_z: v.z, out_w: v.w,
                  corner: crn, last_vertex: last_idx};
  end

  // two-word result queue
  assign oq_pop = pop && (oq_count != 2'd0);

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq[oq_wr] <= emit_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= 1'b0;
      oq_rd    <= 1'b0;
      oq_count <= '0;
    end else begin
      if (oq_push) oq_wr <= ~oq_wr;
      if (oq_pop) oq_rd <= ~oq_rd;
      oq_count <= oq_count + {1'b0, oq_push} - {1'b0, oq_pop};
    end
  end

  assign empty  = (oq_count == 2'd0);
  assign result = oq[oq_rd];

endmodule

>>> src/triangle_cull_near_clip.sv
// ----------------------------------------------------------------------------
// triangle_cull_near_clip
// Culls clip-space triangles and clips them against the near plane z = 0.
// ----------------------------------------------------------------------------
// channel   direction  handshake            word
// item      in         push / full          one triangle, three vertices
// result    out        pop / empty          one vertex, corner, last flag
//
// A triangle with no vertex behind the plane goes straight from taking the job
// to emitting its vertices in the back end. A clipped triangle is taken, then
// the bit-serial alpha dividers run, then the shared interpolation multiplier
// computes the cut points, then the vertices are emitted one after another.
// Culled triangles are dropped in the front end; a two-job queue lets it run
// ahead. Reset is synchronous and empties both queues.
// A stalled result queue stops the back end; the front keeps taking items
// until its queue fills.
// ----------------------------------------------------------------------------
module triangle_cull_near_clip (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  tcnc_pkg::in_t  item,
  output logic           empty,
  input  logic           pop,
  output tcnc_pkg::out_t result
);
  import tcnc_pkg::*;

  logic job_valid, job_take;
  job_t job;

  tcnc_front u_front (
    .clk, .rst, .push, .full, .item, .job_valid, .job, .job_take
  );

  tcnc_back u_back (
    .clk, .rst, .job_valid, .job, .job_take, .empty, .pop, .result
  );

  // checks
  a_corner_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> result.corner != 2'd3)
    else $error("corner out of range");

  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    job_take |-> job_valid)
    else $error("job taken from empty queue");

  a_reset_empty: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (empty && !full))
    else $error("queues not empty after reset");

endmodule
